/* hdl/dmts_pkg.sv */
// Shared types and request codes for the display mode table search block
`default_nettype none

package dmts_pkg;

    // Field widths of one request and one result
    localparam int KIND_W  = 3;
    localparam int DIM_W   = 16;
    localparam int BPP_W   = 8;
    localparam int INDEX_W = 6;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXACT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ATLEAST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PREV    = 3'd5;

    // One table entry as stored in the mode RAM
    typedef struct packed {
        logic [BPP_W-1:0] depth;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } t_mode_entry;

endpackage

`default_nettype wire

/* hdl/display_mode_table_search_core.sv */
// Display mode table search: mode RAM, scan sequencer and result register
// Clear and load: the request goes straight to the output state, from which the result is registered.
// Exact and at-least find: one RAM read per cycle while the table is scanned.
// Next/previous find: exact scan then a neighbour scan.
// One request is worked on at a time; the next is taken once the result is registered.
// Synchronous active-low reset empties the table and drops any pending result.
`default_nettype none

module display_mode_table_search_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Request channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [dmts_pkg::KIND_W-1:0] i_kind,
    input  wire logic [dmts_pkg::DIM_W-1:0]  i_key_width,
    input  wire logic [dmts_pkg::DIM_W-1:0]  i_key_height,
    input  wire logic [dmts_pkg::BPP_W-1:0]  i_key_depth,
    // Result channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_found,
    output logic [dmts_pkg::INDEX_W-1:0]     o_match_index,
    output logic [dmts_pkg::DIM_W-1:0]       o_match_width,
    output logic [dmts_pkg::DIM_W-1:0]       o_match_height
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_NEIGH,
        S_OUT
    } t_state;

    t_state                            r_state;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     r_ptr;
    logic                              r_cmp_vld;
    logic [IW-1:0]                     r_cmp_idx;
    logic [dmts_pkg::KIND_W-1:0]       r_kind;
    logic [dmts_pkg::DIM_W-1:0]        r_kw;
    logic [dmts_pkg::DIM_W-1:0]        r_kh;
    logic [dmts_pkg::BPP_W-1:0]        r_kd;
    // Pending result
    logic                              r_res_found;
    logic [dmts_pkg::INDEX_W-1:0]      r_res_index;
    logic [dmts_pkg::DIM_W-1:0]        r_res_width;
    logic [dmts_pkg::DIM_W-1:0]        r_res_height;
    // Output register
    logic                              r_out_vld;
    logic                              r_out_found;
    logic [dmts_pkg::INDEX_W-1:0]      r_out_index;
    logic [dmts_pkg::DIM_W-1:0]        r_out_width;
    logic [dmts_pkg::DIM_W-1:0]        r_out_height;

    logic                              w_accept;
    logic                              w_wr_en;
    dmts_pkg::t_mode_entry             w_wr_entry;
    logic [$bits(dmts_pkg::t_mode_entry)-1:0] w_rd_data;
    dmts_pkg::t_mode_entry             w_rd_entry;
    logic                              w_back;
    logic                              w_issue_ok;
    logic                              w_rd_en;
    logic [IW-1:0]                     w_rd_addr;
    logic [CW-1:0]                     w_ptr_step;
    logic                              w_bpp_eq;
    logic                              w_exact;
    logic                              w_atleast;
    logic                              w_hit;
    logic                              w_neigh_req;
    logic                              w_out_free;
    logic                              w_out_load;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);

    // Load appends at the fill count while there is room
    assign w_wr_en    = w_accept && (i_kind == dmts_pkg::KIND_LOAD) &&
                        (r_count < CW'(TABLE_DEPTH));
    assign w_wr_entry = '{depth: i_key_depth, height: i_key_height, width: i_key_width};

    // Read address sequencing: forward from r_ptr, or backward below r_ptr
    assign w_back     = (r_state == S_NEIGH) && (r_kind == dmts_pkg::KIND_PREV);
    assign w_issue_ok = w_back ? (r_ptr != '0) : (r_ptr < r_count);
    assign w_rd_addr  = w_back ? IW'(r_ptr - CW'(1)) : IW'(r_ptr);
    assign w_ptr_step = w_back ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
    assign w_rd_en    = ((r_state == S_SCAN) || (r_state == S_NEIGH)) && w_issue_ok;

    dmts_ram #(
        .WIDTH ($bits(dmts_pkg::t_mode_entry)),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IW)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[IW-1:0]),
        .i_wr_data(w_wr_entry),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // Shared compare unit on the entry read last cycle
    assign w_rd_entry  = w_rd_data;
    assign w_bpp_eq    = (w_rd_entry.depth == r_kd);
    assign w_exact     = w_bpp_eq && (w_rd_entry.width == r_kw) &&
                         (w_rd_entry.height == r_kh);
    assign w_atleast   = w_bpp_eq && (w_rd_entry.width >= r_kw) &&
                         (w_rd_entry.height >= r_kh);
    assign w_hit       = (r_state == S_NEIGH) ? w_bpp_eq :
                         (r_kind == dmts_pkg::KIND_ATLEAST) ? w_atleast : w_exact;
    assign w_neigh_req = (r_kind == dmts_pkg::KIND_NEXT) || (r_kind == dmts_pkg::KIND_PREV);

    assign w_out_free = !r_out_vld || !i_stall;
    assign w_out_load = (r_state == S_OUT) && w_out_free;

    // Sequencer, table count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // output slot: filled from the sequencer, or handed over downstream
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    if (i_valid) begin
                        r_kind       <= i_kind;
                        r_kw         <= i_key_width;
                        r_kh         <= i_key_height;
                        r_kd         <= i_key_depth;
                        r_ptr        <= '0;
                        r_res_index  <= '0;
                        r_res_width  <= '0;
                        r_res_height <= '0;
                        case (i_kind)
                            dmts_pkg::KIND_CLEAR: begin
                                r_count     <= '0;
                                r_res_found <= 1'b1;
                                r_state     <= S_OUT;
                            end
                            dmts_pkg::KIND_LOAD: begin
                                r_res_found <= (r_count < CW'(TABLE_DEPTH));
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_OUT;
                            end
                            dmts_pkg::KIND_EXACT,
                            dmts_pkg::KIND_ATLEAST,
                            dmts_pkg::KIND_NEXT,
                            dmts_pkg::KIND_PREV: begin
                                r_res_found <= 1'b0;
                                r_state     <= S_SCAN;
                            end
                            default: begin
                                r_res_found <= 1'b0;
                                r_state     <= S_OUT;
                            end
                        endcase
                    end
                end

                S_SCAN, S_NEIGH: begin
                    if (r_cmp_vld && w_hit) begin
                        r_cmp_vld <= 1'b0;
                        if (r_state == S_NEIGH) begin
                            // neighbour with the same depth
                            r_res_found  <= 1'b1;
                            r_res_width  <= w_rd_entry.width;
                            r_res_height <= w_rd_entry.height;
                            r_state      <= S_OUT;
                        end else if (w_neigh_req) begin
                            // exact match located, turn round for the neighbour scan
                            r_ptr   <= (r_kind == dmts_pkg::KIND_PREV) ? CW'(r_cmp_idx) :
                                       CW'(r_cmp_idx) + CW'(1);
                            r_state <= S_NEIGH;
                        end else begin
                            r_res_found <= 1'b1;
                            r_res_index <= dmts_pkg::INDEX_W'(r_cmp_idx);
                            r_state     <= S_OUT;
                        end
                    end else if (!r_cmp_vld && !w_issue_ok) begin
                        // nothing in flight and nothing left to read: miss
                        r_state <= S_OUT;
                    end else begin
                        r_cmp_vld <= w_issue_ok;
                        r_cmp_idx <= w_rd_addr;
                        if (w_issue_ok) begin
                            r_ptr <= w_ptr_step;
                        end
                    end
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_out_found  <= r_res_found;
                        r_out_index  <= r_res_index;
                        r_out_width  <= r_res_width;
                        r_out_height <= r_res_height;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_found        = r_out_found;
    assign o_match_index  = r_out_index;
    assign o_match_width  = r_out_width;
    assign o_match_height = r_out_height;

`ifndef SYNTHESIS
    // Fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Every RAM read targets a written entry
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (CW'(w_rd_addr) < r_count))
        else $error("read of an entry beyond the fill count");

    // A load into a full table leaves the count alone
    a_full_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == dmts_pkg::KIND_LOAD) && (r_count == CW'(TABLE_DEPTH)))
        |=> (r_count == CW'(TABLE_DEPTH)))
        else $error("load changed a full table");

    // No compare left pending once back in idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_cmp_vld)
        else $error("stale compare in idle");

    // A result is only registered when the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_vld && i_stall) |=> (r_state == S_OUT))
        else $error("result left the sequencer while output was blocked");
`endif

endmodule

`default_nettype wire

/* hdl/dmts_ram.sv */
// Generic single write port, single read port RAM with registered read data
`default_nettype none

module dmts_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data available the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* dv/tb_display_mode_table_search_core.sv */
// Self-checking testbench for the display mode table search core
`timescale 1ns / 1ps

module tb_display_mode_table_search_core;

    // Package widths, request kinds and entry type
    localparam int KIND_W  = dmts_pkg::KIND_W;
    localparam int DIM_W   = dmts_pkg::DIM_W;
    localparam int BPP_W   = dmts_pkg::BPP_W;
    localparam int INDEX_W = dmts_pkg::INDEX_W;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = dmts_pkg::KIND_CLEAR;
    localparam logic [KIND_W-1:0] KIND_LOAD    = dmts_pkg::KIND_LOAD;
    localparam logic [KIND_W-1:0] KIND_EXACT   = dmts_pkg::KIND_EXACT;
    localparam logic [KIND_W-1:0] KIND_ATLEAST = dmts_pkg::KIND_ATLEAST;
    localparam logic [KIND_W-1:0] KIND_NEXT    = dmts_pkg::KIND_NEXT;
    localparam logic [KIND_W-1:0] KIND_PREV    = dmts_pkg::KIND_PREV;

    typedef dmts_pkg::t_mode_entry t_mode_entry;

    localparam int TABLE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET    = 1100;
    localparam int REPORT_MAX     = 10;

    // Kinds the block leaves unused
    localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_search_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [BPP_W-1:0]  depth;
        logic              typed;
        t_search_result    res;
    } t_stim_row;

    localparam t_search_result NO_MATCH = '0;
    localparam t_search_result ACCEPTED = '{1'b1, 6'd0, 16'd0, 16'd0};

    // Directed rows: typed expectations only where obvious, the rest predicted
    localparam int DIRECTED_ROWS = 22;
    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{KIND_EXACT,   16'd0,     16'd0,     8'd0,    1'b1, NO_MATCH},
        '{KIND_NEXT,    16'd0,     16'd0,     8'd0,    1'b1, NO_MATCH},
        '{KIND_CLEAR,   16'hFFFF,  16'hFFFF,  8'hFF,   1'b1, ACCEPTED},
        '{KIND_LOAD,    16'd0,     16'd0,     8'd0,    1'b1, ACCEPTED},
        '{KIND_LOAD,    16'hFFFF,  16'hFFFF,  8'hFF,   1'b1, ACCEPTED},
        '{KIND_LOAD,    16'd640,   16'd480,   8'd8,    1'b1, ACCEPTED},
        '{KIND_LOAD,    16'd800,   16'd600,   8'd8,    1'b1, ACCEPTED},
        '{KIND_LOAD,    16'd1024,  16'd768,   8'd16,   1'b1, ACCEPTED},
        '{KIND_LOAD,    16'd640,   16'd480,   8'd8,    1'b1, ACCEPTED},
        '{KIND_EXACT,   16'hFFFF,  16'hFFFF,  8'hFF,   1'b1, '{1'b1, 6'd1, 16'd0, 16'd0}},
        '{KIND_EXACT,   16'd640,   16'd480,   8'd8,    1'b1, '{1'b1, 6'd2, 16'd0, 16'd0}},
        '{KIND_ATLEAST, 16'd0,     16'd0,     8'd0,    1'b1, '{1'b1, 6'd0, 16'd0, 16'd0}},
        '{KIND_ATLEAST, 16'd700,   16'd500,   8'd8,    1'b0, NO_MATCH},
        '{KIND_ATLEAST, 16'hFFFF,  16'hFFFF,  8'd8,    1'b0, NO_MATCH},
        '{KIND_NEXT,    16'd640,   16'd480,   8'd8,    1'b0, NO_MATCH},
        '{KIND_PREV,    16'd640,   16'd480,   8'd8,    1'b0, NO_MATCH},
        '{KIND_NEXT,    16'd800,   16'd600,   8'd8,    1'b0, NO_MATCH},
        '{KIND_PREV,    16'hFFFF,  16'hFFFF,  8'hFF,   1'b0, NO_MATCH},
        '{KIND_RSVD6,   16'hFFFF,  16'hFFFF,  8'hFF,   1'b1, NO_MATCH},
        '{KIND_RSVD7,   16'd640,   16'd480,   8'd8,    1'b1, NO_MATCH},
        '{KIND_CLEAR,   16'd0,     16'd0,     8'd0,    1'b1, ACCEPTED},
        '{KIND_EXACT,   16'd0,     16'd0,     8'd0,    1'b1, NO_MATCH}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [DIM_W-1:0]    i_key_width;
    logic [DIM_W-1:0]    i_key_height;
    logic [BPP_W-1:0]    i_key_depth;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_found;
    logic [INDEX_W-1:0]  o_match_index;
    logic [DIM_W-1:0]    o_match_width;
    logic [DIM_W-1:0]    o_match_height;

    // Predictor state: the mode table and its fill level
    t_mode_entry mode_table [TABLE_DEPTH];
    int          table_count;

    t_search_result pending_results [$];
    int             mismatch_count;
    int             requests_sent;
    int             burst_left;
    int             idle_cycles = 0;
    int             stall_left  = 0;
    int             stall_mode  = 0;

    display_mode_table_search_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_key_width    (i_key_width),
        .i_key_height   (i_key_height),
        .i_key_depth    (i_key_depth),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_match_index  (o_match_index),
        .o_match_width  (o_match_width),
        .o_match_height (o_match_height)
    );

    always #1 i_clk = ~i_clk;

    // First entry matching all three keys, or -1
    function automatic int find_exact(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                      logic [BPP_W-1:0] d);
        for (int i = 0; i < table_count; i++) begin
            if (mode_table[i].width == w && mode_table[i].height == h &&
                mode_table[i].depth == d) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Expected result of one request; updates the table for clear and load
    function automatic t_search_result predict_result(logic [KIND_W-1:0] kind,
                                                      logic [DIM_W-1:0] w,
                                                      logic [DIM_W-1:0] h,
                                                      logic [BPP_W-1:0] d);
        t_search_result res;
        int hit;
        int i;
        res = '0;
        hit = -1;
        case (kind)
            KIND_CLEAR: begin
                table_count = 0;
                res.found = 1'b1;
            end
            KIND_LOAD: begin
                if (table_count < TABLE_DEPTH) begin
                    mode_table[table_count] = '{depth: d, height: h, width: w};
                    table_count++;
                    res.found = 1'b1;
                end
            end
            KIND_EXACT, KIND_ATLEAST: begin
                if (kind == KIND_EXACT) begin
                    hit = find_exact(w, h, d);
                end else begin
                    for (i = 0; i < table_count && hit < 0; i++) begin
                        if (mode_table[i].width >= w && mode_table[i].height >= h &&
                            mode_table[i].depth == d) begin
                            hit = i;
                        end
                    end
                end
                if (hit >= 0) begin
                    res.found = 1'b1;
                    res.index = hit[INDEX_W-1:0];
                end
            end
            KIND_NEXT, KIND_PREV: begin
                hit = find_exact(w, h, d);
                if (hit >= 0) begin
                    i = (kind == KIND_NEXT) ? hit + 1 : hit - 1;
                    while (i >= 0 && i < table_count && !res.found) begin
                        if (mode_table[i].depth == d) begin
                            res.found  = 1'b1;
                            res.width  = mode_table[i].width;
                            res.height = mode_table[i].height;
                        end
                        i = (kind == KIND_NEXT) ? i + 1 : i - 1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Common sizes make duplicates and same-depth neighbours likely
    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 7))
            0: return 16'd320;
            1: return 16'd640;
            2: return 16'd800;
            3: return 16'd1024;
            4: return 16'd480;
            5: return 16'd600;
            default: return DIM_W'($urandom);
        endcase
    endfunction

    function automatic logic [BPP_W-1:0] rand_depth();
        case ($urandom_range(0, 5))
            0: return 8'd8;
            1: return 8'd16;
            2: return 8'd24;
            3: return 8'd32;
            default: return BPP_W'($urandom);
        endcase
    endfunction

    // Present one request at the falling edge and hold it until taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DIM_W-1:0] w,
                                input logic [DIM_W-1:0] h, input logic [BPP_W-1:0] d,
                                input logic typed, input t_search_result typed_res);
        t_search_result res;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_key_width  <= w;
        i_key_height <= h;
        i_key_depth  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = predict_result(kind, w, h, d);
        pending_results.push_back(typed ? typed_res : res);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Clear, fill, then query mostly with keys taken from the table
    task automatic run_table_episode();
        int n_load;
        int n_query;
        int pos;
        logic [KIND_W-1:0] kind;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [BPP_W-1:0]  d;
        send_request(KIND_CLEAR, DIM_W'($urandom), DIM_W'($urandom), BPP_W'($urandom),
                     1'b0, NO_MATCH);
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        n_query = (n_load > 40) ? $urandom_range(20, 40) : $urandom_range(6, 20);
        for (int j = 0; j < n_load; j++) begin
            send_request(KIND_LOAD, rand_dim(), rand_dim(), rand_depth(), 1'b0, NO_MATCH);
        end
        for (int j = 0; j < n_query; j++) begin
            case ($urandom_range(0, 3))
                0: kind = KIND_EXACT;
                1: kind = KIND_ATLEAST;
                2: kind = KIND_NEXT;
                default: kind = KIND_PREV;
            endcase
            if (table_count > 0 && $urandom_range(0, 9) < 8) begin
                pos = $urandom_range(0, table_count - 1);
                w = mode_table[pos].width;
                h = mode_table[pos].height;
                d = mode_table[pos].depth;
                if (kind == KIND_ATLEAST && $urandom_range(0, 1)) begin
                    w = DIM_W'($urandom_range(0, w));
                    h = DIM_W'($urandom_range(0, h));
                end
            end else begin
                w = rand_dim();
                h = rand_dim();
                d = rand_depth();
            end
            send_request(kind, w, h, d, 1'b0, NO_MATCH);
            if ($urandom_range(0, 9) == 0) begin
                send_request(KIND_LOAD, rand_dim(), rand_dim(), rand_depth(), 1'b0, NO_MATCH);
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_CLEAR;
        i_key_width    = '0;
        i_key_height   = '0;
        i_key_depth    = '0;
        table_count    = 0;
        mismatch_count = 0;
        requests_sent  = 0;
        burst_left     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(DIRECTED[r].kind, DIRECTED[r].width, DIRECTED[r].height,
                         DIRECTED[r].depth, DIRECTED[r].typed, DIRECTED[r].res);
        end
        drain_results();

        while (requests_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                7: begin
                    // noise: any kind, full-range fields
                    for (int j = 0; j < 10; j++) begin
                        send_request(KIND_W'($urandom_range(0, 7)), DIM_W'($urandom),
                                     DIM_W'($urandom), BPP_W'($urandom), 1'b0, NO_MATCH);
                    end
                end
                8: begin
                    drain_results();
                    run_table_episode();
                end
                default: run_table_episode();
            endcase
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver stall: alternating stretches of no, random, heavy and periodic stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= $urandom_range(0, 1);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((stall_left % 8) < 3);
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        t_search_result got;
        t_search_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_found, o_match_index, o_match_width, o_match_height};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("unexpected result: found=%0d index=%0d w=%0d h=%0d",
                             got.found, got.index, got.width, got.height);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("mismatch: exp found=%0d index=%0d w=%0d h=%0d",
                                 want.found, want.index, want.width, want.height);
                        $display("          got found=%0d index=%0d w=%0d h=%0d",
                                 got.found, got.index, got.width, got.height);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no request or result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
